// ----- src/ae_pkg.sv -----
// Shared constants, register indexes and the log2 table for the approximate entropy block.
package ae_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 1024;
  localparam int unsigned MAX_EMBED_DEF   = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned EMBED_W   = 4;
  localparam int unsigned TOL_W     = 16;
  localparam int unsigned ENT_W     = 20;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EMBED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOL   = 2'd1;

  localparam logic [EMBED_W-1:0] EMBED_RESET = 4'd2;
  localparam logic [15:0]        LN2_Q16     = 16'd45426;
  localparam logic [ENT_W-1:0]   ENT_MAX_U   = 20'h7FFFF;
  localparam logic [ENT_W-1:0]   ENT_MIN_U   = 20'h80000;

  // round(65536 * log2(1 + k/16)), k = 0..16
  function automatic logic [16:0] log_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

// ----- src/ae_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module ae_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ----- src/ae_log2.sv -----
// Q16 log2 of an unsigned count: leading one plus table with linear interpolation.
module ae_log2 import ae_pkg::*; #(
  parameter int unsigned IN_W = 11
) (
  input  logic [IN_W-1:0]           x_i,
  output logic [$clog2(IN_W)+16:0]  y_o
);

  localparam int unsigned PW    = $clog2(IN_W);
  localparam int unsigned LOG_W = PW + 17;

  logic [PW-1:0]      pos;
  logic [IN_W+15:0]   norm;
  logic [15:0]        frac;
  logic [3:0]         k;
  logic [11:0]        rem;
  logic [16:0]        t_lo;
  logic [16:0]        t_hi;
  logic [12:0]        delta;
  logic [25:0]        prod;
  logic [13:0]        interp;

  // leading one position
  always_comb begin
    pos = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (x_i[b]) begin
        pos = PW'(b);
      end
    end
  end

  assign norm   = {x_i, 16'b0} >> pos;
  assign frac   = norm[15:0];
  assign k      = frac[15:12];
  assign rem    = frac[11:0];
  assign t_lo   = log_tab({1'b0, k});
  assign t_hi   = log_tab({1'b0, k} + 5'd1);
  assign delta  = 13'(t_hi - t_lo);
  assign prod   = (26'(delta) * 26'(rem)) + 26'd2048;
  assign interp = prod[25:12];

  assign y_o = (x_i == '0) ? '0
             : LOG_W'({pos, 16'b0}) + LOG_W'(t_lo) + LOG_W'(interp);

endmodule

// ----- src/approximate_entropy.sv -----
// Top level of the approximate entropy block: sample store, pair sequencer and result arithmetic.
//
// Usage:
//   Input requests: present sample_i and last_i with start_i; a request is taken at a
//   rising edge with start_i high and busy_o low. Samples load at one per cycle into the
//   sample store. A request with last_i high closes the record and starts the work; busy_o
//   then stays high until the result has been shown.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 embed_length, 1 tolerance)
//   and cfg_data_i; cfg_ready_o is always high. Write only while the block is idle.
//   Result: done_o is high for exactly one cycle with entropy_o (signed Q4.16) and status_o
//   (1: record too short or too long, entropy 0). The receiver cannot stall the block.
//   Operation: a sample without last gives no result. An error record goes from S_CHECK
//   straight to S_OUT and shows its result there. A good record of n samples, with
//   N = n-m+1 vectors, runs on a single comparison datapath and a single log2 unit:
//   it clears the N counts, then for every pair (i,j) reads the samples and updates the
//   counts, for every row reads and writes back its counts, for every vector takes the
//   logs, and ends with two restoring divisions of one quotient bit per cycle.
//   Reset: configuration returns to embed_length 2, tolerance 0; the record is emptied.
module approximate_entropy import ae_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int unsigned MAX_EMBED   = MAX_EMBED_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [TOL_W-1:0]              cfg_data_i,
  output logic                          done_o,
  output logic signed [ENT_W-1:0]       entropy_o,
  output logic                          status_o
);

  localparam int unsigned AW      = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned EW      = $clog2(MAX_EMBED + 1);
  localparam int unsigned PW      = $clog2(CNT_W);
  localparam int unsigned LOG_W   = PW + 17;
  localparam int unsigned SUM_W   = LOG_W + CNT_W;
  localparam int unsigned DIFF_W  = LOG_W + 2;
  localparam int unsigned DIST_W  = SAMPLE_BITS + 1;
  localparam int unsigned CMP_W   = (DIST_W > TOL_W) ? DIST_W : TOL_W;
  localparam int unsigned DCNT_W  = $clog2(SUM_W);
  localparam int unsigned PROD_W  = DIFF_W + 16;

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_CHECK   = 18'h00002,
    S_CLR     = 18'h00004,
    S_ROW_RD  = 18'h00008,
    S_ROW_LD  = 18'h00010,
    S_SMP_RD  = 18'h00020,
    S_SMP_CMP = 18'h00040,
    S_CNT_RD  = 18'h00080,
    S_CNT_WR  = 18'h00100,
    S_ROW_WB  = 18'h00200,
    S_LG_RD   = 18'h00400,
    S_LG_S    = 18'h00800,
    S_LG_L    = 18'h01000,
    S_DIV     = 18'h02000,
    S_LG_N    = 18'h04000,
    S_MUL     = 18'h08000,
    S_RND     = 18'h10000,
    S_OUT     = 18'h20000
  } state_e;

  state_e state_q;

  // configuration
  logic [EMBED_W-1:0] embed_q;
  logic [TOL_W-1:0]   tol_q;

  // record bookkeeping
  logic [CNT_W-1:0] total_q, total_d;
  logic             ovf_q, err_q;
  logic [CNT_W-1:0] n_q, nm_q;
  logic [EW-1:0]    m_q, m_eff;

  // pair loop
  logic [CNT_W-1:0]  i_q, j_q;
  logic [EW-1:0]     t_q;
  logic [DIST_W-1:0] dm_q, dl_q;
  logic [CNT_W-1:0]  ci_s_q, ci_l_q, cl_q;
  logic              ms_q, ml_q;

  // sums, divider and result
  logic [SUM_W-1:0]         sum_s_q, sum_l_q;
  logic [SUM_W-1:0]         div_num_q;
  logic [CNT_W-1:0]         div_rem_q, div_den_q;
  logic [DCNT_W-1:0]        div_cnt_q;
  logic                     phase_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [PROD_W-1:0]        prod_q;
  logic                     neg_q;
  logic [ENT_W-1:0]         ent_q;
  logic                     status_q;

  logic accept, room, short_rec, last_j, last_t;

  // ---------------------------------------------------------------------------
  // Clamp the embedding dimension into 1..MAX_EMBED
  always_comb begin
    if (embed_q == '0) begin
      m_eff = EW'(1);
    end else if (32'(embed_q) > MAX_EMBED) begin
      m_eff = EW'(MAX_EMBED);
    end else begin
      m_eff = EW'(embed_q);
    end
  end

  assign accept    = start_i && (state_q == S_IDLE);
  assign busy_o    = (state_q != S_IDLE);
  assign room      = (total_q < CNT_W'(MAX_SAMPLES));
  assign total_d   = room ? total_q + CNT_W'(1) : total_q;
  assign short_rec = (32'(n_q) < (32'(m_eff) + 32'd2));
  // last vector of the short length has no long partner
  assign last_j    = (j_q + CNT_W'(1) == nm_q);
  assign last_t    = last_j ? (t_q + EW'(1) == m_q) : (t_q == m_q);

  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Sample store: written while loading, read at i+t and j+t while comparing
  logic [CNT_W-1:0]       sa_a, sa_b;
  logic [SAMPLE_BITS-1:0] smp_a, smp_b;
  logic signed [DIST_W-1:0] sdiff;
  logic [DIST_W-1:0]      abs_dist;

  assign sa_a = i_q + CNT_W'(t_q);
  assign sa_b = j_q + CNT_W'(t_q);

  ae_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_SAMPLES)
  ) u_sample_ram (
    .clk_i     (clk_i),
    .we_i      (accept && room),
    .waddr_i   (total_q[AW-1:0]),
    .wdata_i   (sample_i),
    .raddr_a_i (sa_a[AW-1:0]),
    .rdata_a_o (smp_a),
    .raddr_b_i (sa_b[AW-1:0]),
    .rdata_b_o (smp_b)
  );

  assign sdiff    = DIST_W'($signed(smp_a)) - DIST_W'($signed(smp_b));
  assign abs_dist = (sdiff < 0) ? DIST_W'(-sdiff) : DIST_W'(sdiff);

  // ---------------------------------------------------------------------------
  // Match counts: short count in the upper half, long count in the lower half
  logic                   cnt_we;
  logic [CNT_W-1:0]       cnt_waddr, cnt_raddr;
  logic [2*CNT_W-1:0]     cnt_wdata, cnt_rdata;
  logic [CNT_W-1:0]       rd_s, rd_l;

  assign rd_s = cnt_rdata[2*CNT_W-1:CNT_W];
  assign rd_l = cnt_rdata[CNT_W-1:0];

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = i_q;
    cnt_wdata = {ci_s_q, ci_l_q};
    cnt_raddr = i_q;
    unique case (state_q)
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_wdata = {CNT_W'(1), CNT_W'(1)};
      end
      S_CNT_RD: begin
        cnt_raddr = j_q;
      end
      S_CNT_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = j_q;
        cnt_wdata = {rd_s + CNT_W'(ms_q), rd_l + CNT_W'(ml_q)};
      end
      S_ROW_WB: begin
        cnt_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  ae_ram #(
    .WIDTH (2 * CNT_W),
    .DEPTH (MAX_SAMPLES)
  ) u_count_ram (
    .clk_i     (clk_i),
    .we_i      (cnt_we),
    .waddr_i   (cnt_waddr[AW-1:0]),
    .wdata_i   (cnt_wdata),
    .raddr_a_i (cnt_raddr[AW-1:0]),
    .rdata_a_o (cnt_rdata),
    .raddr_b_i (cnt_raddr[AW-1:0]),
    .rdata_b_o ()
  );

  // ---------------------------------------------------------------------------
  // Shared log2 unit
  logic [CNT_W-1:0] log_x;
  logic [LOG_W-1:0] log_y;

  always_comb begin
    unique case (state_q)
      S_LG_S:  log_x = rd_s;
      S_LG_L:  log_x = cl_q;
      S_LG_N:  log_x = phase_q ? nm_q - CNT_W'(1) : nm_q;
      default: log_x = nm_q;
    endcase
  end

  ae_log2 #(
    .IN_W (CNT_W)
  ) u_log2 (
    .x_i (log_x),
    .y_o (log_y)
  );

  // ---------------------------------------------------------------------------
  // Restoring divider step, one quotient bit a cycle
  logic [CNT_W:0]   rem_sh;
  logic             div_ge;
  logic [CNT_W-1:0] rem_nx;
  logic [SUM_W-1:0] num_nx;
  logic             div_last;

  assign rem_sh   = {div_rem_q, div_num_q[SUM_W-1]};
  assign div_ge   = (rem_sh >= {1'b0, div_den_q});
  assign rem_nx   = div_ge ? CNT_W'(rem_sh - {1'b0, div_den_q}) : rem_sh[CNT_W-1:0];
  assign num_nx   = {div_num_q[SUM_W-2:0], div_ge};
  assign div_last = (div_cnt_q == DCNT_W'(SUM_W - 1));

  // ---------------------------------------------------------------------------
  // Scaling and saturation
  logic [DIFF_W-1:0] mag;
  logic [PROD_W-1:0] prod_rnd;
  logic [DIFF_W-1:0] qv;
  logic [ENT_W-1:0]  ent_sat;

  assign mag      = (diff_q < 0) ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
  assign prod_rnd = prod_q + PROD_W'(32768);
  assign qv       = prod_rnd[PROD_W-1:16];

  always_comb begin
    if (neg_q) begin
      ent_sat = (qv > DIFF_W'(524288)) ? ENT_MIN_U : ENT_W'(DIFF_W'(0) - qv);
    end else begin
      ent_sat = (qv > DIFF_W'(524287)) ? ENT_MAX_U : ENT_W'(qv);
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      embed_q <= EMBED_RESET;
      tol_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_EMBED: embed_q <= cfg_data_i[EMBED_W-1:0];
        REG_TOL:   tol_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      total_q   <= '0;
      ovf_q     <= 1'b0;
      err_q     <= 1'b0;
      n_q       <= '0;
      nm_q      <= '0;
      m_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      t_q       <= '0;
      dm_q      <= '0;
      dl_q      <= '0;
      ci_s_q    <= '0;
      ci_l_q    <= '0;
      cl_q      <= '0;
      ms_q      <= 1'b0;
      ml_q      <= 1'b0;
      sum_s_q   <= '0;
      sum_l_q   <= '0;
      div_num_q <= '0;
      div_rem_q <= '0;
      div_den_q <= '0;
      div_cnt_q <= '0;
      phase_q   <= 1'b0;
      diff_q    <= '0;
      prod_q    <= '0;
      neg_q     <= 1'b0;
      ent_q     <= '0;
      status_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (last_i) begin
              // close the record and start the work
              n_q     <= total_d;
              err_q   <= ovf_q || !room;
              total_q <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_CHECK;
            end else begin
              total_q <= total_d;
              ovf_q   <= ovf_q || !room;
            end
          end
        end
        S_CHECK: begin
          m_q <= m_eff;
          if (err_q || short_rec) begin
            ent_q    <= '0;
            status_q <= 1'b1;
            state_q  <= S_OUT;
          end else begin
            nm_q    <= n_q - CNT_W'(m_eff) + CNT_W'(1);
            i_q     <= '0;
            state_q <= S_CLR;
          end
        end
        S_CLR: begin
          // every vector matches itself
          if (i_q + CNT_W'(1) == nm_q) begin
            i_q     <= '0;
            state_q <= S_ROW_RD;
          end else begin
            i_q <= i_q + CNT_W'(1);
          end
        end
        S_ROW_RD: begin
          state_q <= S_ROW_LD;
        end
        S_ROW_LD: begin
          ci_s_q <= rd_s;
          ci_l_q <= rd_l;
          j_q    <= i_q + CNT_W'(1);
          t_q    <= '0;
          dm_q   <= '0;
          dl_q   <= '0;
          if (i_q + CNT_W'(1) == nm_q) begin
            state_q <= S_ROW_WB;
          end else begin
            state_q <= S_SMP_RD;
          end
        end
        S_SMP_RD: begin
          state_q <= S_SMP_CMP;
        end
        S_SMP_CMP: begin
          // Chebyshev distance over m taps, and over m+1 for the long vector
          if ((t_q != m_q) && (abs_dist > dm_q)) begin
            dm_q <= abs_dist;
          end
          if (abs_dist > dl_q) begin
            dl_q <= abs_dist;
          end
          if (last_t) begin
            state_q <= S_CNT_RD;
          end else begin
            t_q     <= t_q + EW'(1);
            state_q <= S_SMP_RD;
          end
        end
        S_CNT_RD: begin
          ms_q    <= (CMP_W'(dm_q) <= CMP_W'(tol_q));
          ml_q    <= !last_j && (CMP_W'(dl_q) <= CMP_W'(tol_q));
          ci_s_q  <= ci_s_q + CNT_W'(CMP_W'(dm_q) <= CMP_W'(tol_q));
          ci_l_q  <= ci_l_q + CNT_W'(!last_j && (CMP_W'(dl_q) <= CMP_W'(tol_q)));
          state_q <= S_CNT_WR;
        end
        S_CNT_WR: begin
          t_q  <= '0;
          dm_q <= '0;
          dl_q <= '0;
          j_q  <= j_q + CNT_W'(1);
          if (last_j) begin
            state_q <= S_ROW_WB;
          end else begin
            state_q <= S_SMP_RD;
          end
        end
        S_ROW_WB: begin
          if (i_q + CNT_W'(1) == nm_q) begin
            i_q     <= '0;
            sum_s_q <= '0;
            sum_l_q <= '0;
            state_q <= S_LG_RD;
          end else begin
            i_q     <= i_q + CNT_W'(1);
            state_q <= S_ROW_RD;
          end
        end
        S_LG_RD: begin
          state_q <= S_LG_S;
        end
        S_LG_S: begin
          sum_s_q <= sum_s_q + SUM_W'(log_y);
          cl_q    <= rd_l;
          state_q <= S_LG_L;
        end
        S_LG_L: begin
          if (i_q + CNT_W'(1) != nm_q) begin
            sum_l_q <= sum_l_q + SUM_W'(log_y);
            i_q     <= i_q + CNT_W'(1);
            state_q <= S_LG_RD;
          end else begin
            // average of the short logs first
            div_num_q <= sum_s_q + SUM_W'(nm_q >> 1);
            div_den_q <= nm_q;
            div_rem_q <= '0;
            div_cnt_q <= '0;
            phase_q   <= 1'b0;
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          div_num_q <= num_nx;
          div_rem_q <= rem_nx;
          div_cnt_q <= div_cnt_q + DCNT_W'(1);
          if (div_last) begin
            div_cnt_q <= '0;
            div_rem_q <= '0;
            if (!phase_q) begin
              diff_q    <= DIFF_W'(num_nx);
              div_num_q <= sum_l_q + SUM_W'((nm_q - CNT_W'(1)) >> 1);
              div_den_q <= nm_q - CNT_W'(1);
              phase_q   <= 1'b1;
            end else begin
              diff_q  <= diff_q - DIFF_W'(num_nx);
              phase_q <= 1'b0;
              state_q <= S_LG_N;
            end
          end
        end
        S_LG_N: begin
          if (!phase_q) begin
            diff_q  <= diff_q - DIFF_W'(log_y);
            phase_q <= 1'b1;
          end else begin
            diff_q  <= diff_q + DIFF_W'(log_y);
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= PROD_W'(mag) * PROD_W'(LN2_Q16);
          neg_q   <= (diff_q < 0);
          state_q <= S_RND;
        end
        S_RND: begin
          ent_q    <= ent_sat;
          status_q <= 1'b0;
          state_q  <= S_OUT;
        end
        S_OUT: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o    = (state_q == S_OUT);
  assign entropy_o = ent_q;
  assign status_o  = status_q;

endmodule

// ----- src/ae_checker.sv -----
// Port-level checker for the approximate entropy block, bound to the top level.
module ae_checker import ae_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic             last_i,
  input logic             done_o,
  input logic [ENT_W-1:0] entropy_o,
  input logic             status_o
);

  // one result per record, never two in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // a sample without last gives no result and leaves the block free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !last_i) |=> (!busy_o && !done_o))
    else $error("plain sample caused busy or a result");

  // a closing sample makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_i) |=> busy_o)
    else $error("block not busy after last sample");

  // error result carries zero entropy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (entropy_o == '0))
    else $error("error result with non-zero entropy");

  // free again right after a result
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy_o)
    else $error("block still busy after result");

endmodule

bind approximate_entropy ae_checker u_ae_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .last_i    (last_i),
  .done_o    (done_o),
  .entropy_o (entropy_o),
  .status_o  (status_o)
);

// ----- sim/approximate_entropy_tb.sv -----
// Testbench for the approximate entropy block: directed table, random records, scoreboard.
`timescale 1ns / 1ps

module approximate_entropy_tb;
  import ae_pkg::*;

  localparam int unsigned DEPTH = MAX_SAMPLES_DEF;

  typedef struct packed {
    logic signed [ENT_W-1:0] entropy;
    logic                    status;
  } apen_res_t;

  typedef struct {
    logic signed [15:0] sample;
    logic               last;
    bit                 typed;   // expectation written into the table
    apen_res_t          res;
  } stim_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic                    busy_o;
  logic signed [15:0]      sample_i = '0;
  logic                    last_i = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = REG_EMBED;
  logic [TOL_W-1:0]        cfg_data_i = '0;
  logic                    done_o;
  logic signed [ENT_W-1:0] entropy_o;
  logic                    status_o;

  approximate_entropy dut (.*);

  always #5 clk_i = ~clk_i;

  // Model state: the open record, the lost-sample flag and the register copies.
  logic signed [15:0] record_q[$];
  bit                 record_lost;
  logic [3:0]         embed_cfg = EMBED_RESET;
  logic [15:0]        tol_cfg = '0;
  apen_res_t          pending_q[$];
  int                 errors = 0;

  localparam longint unsigned LOG_TAB[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109,
    34312, 38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};

  // log2 in Q16: leading-one position plus table with linear interpolation.
  function automatic longint unsigned log2_fix(input int unsigned x);
    int unsigned     p;
    longint unsigned frac, k, rem;
    p = 0;
    if (x == 0) return 0;
    for (int i = 31; i > 0; i--) begin
      if (x[i]) begin
        p = i;
        break;
      end
    end
    if (p <= 16) frac = (longint'(x) << (16 - p)) & 64'hFFFF;
    else frac = (longint'(x) >> (p - 16)) & 64'hFFFF;
    k   = frac >> 12;
    rem = frac & 64'hFFF;
    return (longint'(p) << 16) + LOG_TAB[k]
         + (((LOG_TAB[k+1] - LOG_TAB[k]) * rem + 2048) >> 12);
  endfunction

  // Entropy of the closed record; status 1 for a short or truncated record.
  function automatic apen_res_t apen_of_record();
    apen_res_t       r;
    int unsigned     n, m, nv, nv1;
    int unsigned     cs[], cl[];
    longint          dm, d1, d, diff, res;
    longint unsigned ss, sl, mag, q;
    n = record_q.size();
    m = (embed_cfg < 1) ? 1 : (embed_cfg > MAX_EMBED_DEF) ? MAX_EMBED_DEF : embed_cfg;
    r.entropy = '0;
    r.status  = 1'b1;
    if (record_lost || n < m + 2) return r;
    nv  = n - m + 1;
    nv1 = n - m;
    cs = new[nv];
    cl = new[nv];
    foreach (cs[i]) begin
      cs[i] = 1;
      cl[i] = 1;
    end
    for (int i = 0; i < nv; i++) begin
      for (int j = i + 1; j < nv; j++) begin
        dm = 0;
        for (int t = 0; t < m; t++) begin
          d = longint'(record_q[i+t]) - longint'(record_q[j+t]);
          if (d < 0) d = -d;
          if (d > dm) dm = d;
        end
        if (dm <= longint'(tol_cfg)) begin
          cs[i]++;
          cs[j]++;
        end
        if (j < nv1) begin
          d1 = longint'(record_q[i+m]) - longint'(record_q[j+m]);
          if (d1 < 0) d1 = -d1;
          if (dm > d1) d1 = dm;
          if (d1 <= longint'(tol_cfg)) begin
            cl[i]++;
            cl[j]++;
          end
        end
      end
    end
    ss = 0;
    sl = 0;
    for (int i = 0; i < nv; i++) ss += log2_fix(cs[i]);
    for (int i = 0; i < nv1; i++) sl += log2_fix(cl[i]);
    diff = longint'((ss + nv / 2) / nv) - longint'(log2_fix(nv))
         - longint'((sl + nv1 / 2) / nv1) + longint'(log2_fix(nv1));
    mag = (diff < 0) ? -diff : diff;
    q = (mag * LN2_Q16 + 32768) >> 16;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    res = (diff < 0) ? -longint'(q) : longint'(q);
    if (res > 524287) res = 524287;
    if (res < -524288) res = -524288;
    r.entropy = res[ENT_W-1:0];
    r.status  = 1'b0;
    return r;
  endfunction

  // Take one accepted request into the model; returns 1 when it closes a record.
  function automatic bit take_sample(input logic signed [15:0] s, input logic l,
                                     output apen_res_t r);
    if (record_q.size() < DEPTH) record_q.push_back(s);
    else record_lost = 1'b1;
    if (!l) return 0;
    r = apen_of_record();
    record_q.delete();
    record_lost = 1'b0;
    return 1;
  endfunction

  // Drive one request, idling at the given rate first; hold it until taken.
  task automatic send_sample(input logic signed [15:0] s, input logic l, input int idle_pct,
                             input bit typed = 0, input apen_res_t typed_res = '0);
    apen_res_t r;
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    start_i  = 1'b1;
    sample_i = s;
    last_i   = l;
    do @(posedge clk_i); while (busy_o);
    if (take_sample(s, l, r)) pending_q.push_back(typed ? typed_res : r);
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  // Let the block drain, then write one register.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOL_W-1:0] val);
    wait (pending_q.size() == 0);
    repeat (8) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_EMBED) embed_cfg = val[3:0];
    else tol_cfg = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Scoreboard: every strobe must meet the oldest expectation.
  always @(posedge clk_i) begin
    apen_res_t e;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result entropy %0d status %0b", $realtime, entropy_o,
                 status_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (entropy_o !== e.entropy) begin
          $display("%0t: entropy expected %0d actual %0d", $realtime, e.entropy, entropy_o);
          errors++;
        end
        if (status_o !== e.status) begin
          $display("%0t: status expected %0b actual %0b", $realtime, e.status, status_o);
          errors++;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #60ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    stim_row_t   table_rows[$];
    stim_row_t   row;
    int          idle_pct, len, sent, ovf_phase;
    logic [3:0]  embeds[6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2};
    logic [15:0] tols[6]   = '{16'd0, 16'd65535, 16'd100, 16'd5000, 16'd1000, 16'd30000};
    logic signed [15:0] s;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table at the reset settings (m = 2, tolerance 0).
    // A lone last sample: record too short.
    table_rows.push_back('{16'sd5, 1'b1, 1, '{20'sd0, 1'b1}});
    // Three samples, two at the extremes: still one short of m+2.
    table_rows.push_back('{16'sh7FFF, 1'b0, 0, '0});
    table_rows.push_back('{16'sh8000, 1'b0, 0, '0});
    table_rows.push_back('{16'sd0, 1'b1, 1, '{20'sd0, 1'b1}});
    // Shortest good record, alternating extremes: widest distances.
    table_rows.push_back('{16'sh8000, 1'b0, 0, '0});
    table_rows.push_back('{16'sh7FFF, 1'b0, 0, '0});
    table_rows.push_back('{16'sh8000, 1'b0, 0, '0});
    table_rows.push_back('{16'sh7FFF, 1'b1, 0, '0});
    // Constant record: every vector matches every other one.
    repeat (6) table_rows.push_back('{16'sh7FFF, 1'b0, 0, '0});
    table_rows.push_back('{16'sh7FFF, 1'b1, 0, '0});
    // Ramp: only self matches at tolerance zero.
    for (int i = 0; i < 7; i++)
      table_rows.push_back('{16'(-3 + i), (i == 6), 0, '0});
    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_sample(row.sample, row.last, 0, row.typed, row.res);
    end

    // Random phases: each with its own settings and idle rate.
    ovf_phase = $urandom_range(5);
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_EMBED, {12'd0, embeds[ph]});
      write_reg(REG_TOL, tols[ph]);
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 47 : 31;
      sent = 0;
      // One record overruns the store: samples past the end are lost, status 1.
      if (ph == ovf_phase) begin
        for (int i = 0; i < DEPTH + 6; i++)
          send_sample(16'($urandom), (i == DEPTH + 5), idle_pct);
      end
      while (sent < 95) begin
        case ($urandom_range(9))
          0:       len = $urandom_range(1, 10);   // often too short for the embedding
          1:       len = $urandom_range(30, 40);
          default: len = $urandom_range(4, 20);
        endcase
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(3) == 0) s = 16'($urandom);
          else s = 16'($signed($urandom_range(0, 4000)) - 2000);
          send_sample(s, (i == len - 1), idle_pct);
        end
        sent += len;
        // Pressure: hold off until the block has answered everything.
        if ($urandom_range(7) == 0) wait (pending_q.size() == 0);
      end
    end

    wait (pending_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
